[rtl/bvsr_pkg.sv]
// Shared types and constants for the bias voltage step regulator.
// Holds the transaction payload structs, op and phase codes, and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bvsr_pkg;

    // Field widths fixed by the interface.
    localparam int ADC_BITS    = 12;
    localparam int DUTY_W      = 16;
    localparam int OP_W        = 2;
    localparam int PHASE_W     = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Input transaction operation codes.
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
    localparam logic [OP_W-1:0] OP_STEP   = 2'd2;
    localparam logic [OP_W-1:0] OP_MODE   = 2'd3;

    // Control loop phase codes.
    localparam logic [PHASE_W-1:0] PH_RISE   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_FALL   = 2'd1;
    localparam logic [PHASE_W-1:0] PH_STABLE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DUTY      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PWM_PERIOD    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DROP_THRESH   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DOWN_STEP_MS  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESET_DUTY    = 3'd4;

    // Register reset values.
    localparam logic [DUTY_W-1:0]   MAX_DUTY_RST    = 16'd1000;
    localparam logic [DUTY_W-1:0]   PWM_PERIOD_RST  = 16'd2000;
    localparam logic [ADC_BITS-1:0] DROP_THRESH_RST = 12'd100;
    localparam logic [DUTY_W-1:0]   DOWN_STEP_RST   = 16'd200;
    localparam logic [DUTY_W-1:0]   RESET_DUTY      = 16'd100;

    // Lowest duty that a decrease step may start from.
    localparam logic [DUTY_W-1:0]   MIN_DUTY        = 16'd10;
    localparam logic [DUTY_W-1:0]   DUTY_TOP        = 16'hFFFF;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [ADC_BITS-1:0] sample;
        logic                cmd_manual;
        logic [DUTY_W-1:0]   cmd_duty;
        logic [ADC_BITS-1:0] cmd_target_code;
    } in_item_t;

    typedef struct packed {
        logic [DUTY_W-1:0]   pwm_compare;
        logic [ADC_BITS-1:0] measured_code;
        logic [PHASE_W-1:0]  loop_state;
        logic                feedback_on;
    } out_item_t;

    // Capture control from the top level to the averager.
    typedef struct packed {
        logic sample_en;
        logic restart;
    } cap_ctrl_t;

endpackage

`default_nettype wire

[rtl/bvsr_capture.sv]
// Sample capture and averaging for the bias voltage step regulator.
// Keeps the sample store, its running sum and the capture index; outputs the mean.
// Depends on bvsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bvsr_capture #(
    parameter int AVG_SAMPLES = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire bvsr_pkg::cap_ctrl_t          ctrl,
    input  wire logic [bvsr_pkg::ADC_BITS-1:0] sample,
    output logic      [bvsr_pkg::ADC_BITS-1:0] mean
);

    localparam int CAPTURE_LEN = AVG_SAMPLES + 1;
    localparam int WI_W        = $clog2(AVG_SAMPLES + 2);
    localparam int SLOT_W      = $clog2(AVG_SAMPLES);
    localparam int LOG_N       = $clog2(AVG_SAMPLES);
    localparam int SUM_W       = bvsr_pkg::ADC_BITS + LOG_N;
    localparam int SHIFT       = SUM_W + LOG_N;
    localparam int RECIP_W     = SUM_W + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    // Rounded-up reciprocal; exact floor division for every sum below 2**SUM_W.
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES));

    logic [WI_W-1:0]               wi_reg;
    logic [WI_W-1:0]               wi_next;
    logic [SUM_W-1:0]              sum_reg;
    logic [SUM_W-1:0]              sum_next;
    logic                          filled_reg;
    logic                          filled_next;
    logic [bvsr_pkg::ADC_BITS-1:0] rd_data_reg;
    logic [bvsr_pkg::ADC_BITS-1:0] old_value;
    logic [SLOT_W-1:0]             wr_slot;
    logic                          wr_en;
    logic [SLOT_W-1:0]             rd_addr_next;
    logic [PROD_W-1:0]             product;
    logic [bvsr_pkg::ADC_BITS-1:0] store_mem [AVG_SAMPLES];

    // Until the first capture completes, the slot about to be written was never
    // written, so its old value is taken as zero.
    assign old_value = filled_reg ? rd_data_reg : '0;
    assign wr_slot   = SLOT_W'(wi_reg - 1'b1);

    // Capture index, running sum and store write.
    always_comb
    begin
        wi_next     = wi_reg;
        sum_next    = sum_reg;
        filled_next = filled_reg;
        wr_en       = 1'b0;
        if (ctrl.sample_en && (wi_reg < WI_W'(CAPTURE_LEN)))
        begin
            // The first sample of a capture is dropped.
            if (wi_reg != '0)
            begin
                wr_en    = 1'b1;
                sum_next = sum_reg - SUM_W'(old_value) + SUM_W'(sample);
                if (wr_slot == SLOT_W'(AVG_SAMPLES - 1))
                begin
                    filled_next = 1'b1;
                end
            end
            wi_next = wi_reg + 1'b1;
        end
        else if (ctrl.restart && (wi_reg >= WI_W'(CAPTURE_LEN)))
        begin
            wi_next = '0;
        end
    end

    // Prefetch the slot that the next sample will overwrite. It never equals the
    // slot written in the same cycle.
    always_comb
    begin
        if ((wi_next != '0) && (wi_next <= WI_W'(AVG_SAMPLES)))
        begin
            rd_addr_next = SLOT_W'(wi_next - 1'b1);
        end
        else
        begin
            rd_addr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wi_reg     <= '0;
            sum_reg    <= '0;
            filled_reg <= 1'b0;
        end
        else
        begin
            wi_reg     <= wi_next;
            sum_reg    <= sum_next;
            filled_reg <= filled_next;
        end
    end

    // Sample store with registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_slot] <= sample;
        end
        rd_data_reg <= store_mem[rd_addr_next];
    end

    // Mean by multiplication with the reciprocal of the sample count.
    assign product = PROD_W'(sum_reg) * PROD_W'(RECIP);
    assign mean    = product[SHIFT +: bvsr_pkg::ADC_BITS];

endmodule

`default_nettype wire

[rtl/bias_voltage_step_regulator.sv]
// Top level of the bias voltage step regulator: handshakes, configuration,
// three-phase duty loop and a two-entry result buffer.
// Depends on bvsr_pkg and bvsr_capture.
//
//   Channel  | Signals                          | Direction | Transfer
//   ---------+----------------------------------+-----------+-----------------------
//   input    | in_valid, in_ready, in_data      | in        | valid and ready high
//   result   | out_valid, out_ready, out_data   | out       | valid and ready high
//   config   | cfg_we, cfg_index, cfg_wdata     | in        | write enable high
//
// A result is registered on acceptance and shown in the next cycle unless the head
// slot stalls; a new transaction can be accepted every cycle while in_ready is high.
// The longest path runs from the running sum through the reciprocal multiplier
// into the loop compares and the duty select.
// Two result slots let a transaction be accepted while an earlier result stalls;
// in_ready drops only when both slots are full.
// Reset is asynchronous; there is no clearing pass, the first capture pass
// stands in for the cleared store.
`timescale 1ns / 1ps
`default_nettype none

module bias_voltage_step_regulator #(
    parameter int AVG_SAMPLES = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire bvsr_pkg::in_item_t               in_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output bvsr_pkg::out_item_t                   out_data,
    input  wire logic                             cfg_we,
    input  wire logic [bvsr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [bvsr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int AW = bvsr_pkg::ADC_BITS;
    localparam int DW = bvsr_pkg::DUTY_W;
    localparam int PW = bvsr_pkg::PHASE_W;

    // Configuration registers.
    logic [DW-1:0] max_duty_reg;
    logic [DW-1:0] pwm_period_reg;
    logic [AW-1:0] drop_thresh_reg;
    logic [DW-1:0] down_step_reg;

    // Loop state.
    logic [AW-1:0] measured_reg;
    logic [AW-1:0] measured_next;
    logic [AW-1:0] target_reg;
    logic [AW-1:0] target_next;
    logic [AW-1:0] stable_reg;
    logic [AW-1:0] stable_next;
    logic [PW-1:0] phase_reg;
    logic [PW-1:0] phase_next;
    logic          enable_reg;
    logic          enable_next;
    logic [DW-1:0] duty_reg;
    logic [DW-1:0] duty_next;
    logic [DW-1:0] compare_reg;
    logic [DW-1:0] compare_next;
    logic [DW-1:0] wait_reg;
    logic [DW-1:0] wait_next;

    // Result buffer.
    bvsr_pkg::out_item_t head_reg;
    bvsr_pkg::out_item_t skid_reg;
    logic                head_valid_reg;
    logic                skid_valid_reg;
    bvsr_pkg::out_item_t result;

    logic                accept;
    logic                pop;
    bvsr_pkg::cap_ctrl_t cap_ctrl;
    logic [AW-1:0]       mean;
    logic [DW-1:0]       duty_inc;
    logic [DW-1:0]       duty_dec;
    logic                duty_at_max;
    logic                drop_seen;

    assign in_ready  = !skid_valid_reg;
    assign accept    = in_valid && in_ready;
    assign out_valid = head_valid_reg;
    assign out_data  = head_reg;
    assign pop       = head_valid_reg && out_ready;

    // Averager.
    assign cap_ctrl.sample_en = accept && (in_data.op == bvsr_pkg::OP_SAMPLE);
    assign cap_ctrl.restart   = accept && (in_data.op == bvsr_pkg::OP_STEP);

    bvsr_capture #(
        .AVG_SAMPLES(AVG_SAMPLES)
    ) u_capture (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (cap_ctrl),
        .sample (in_data.sample),
        .mean   (mean)
    );

    // Configuration writes. There is no reset duty register: a write to its index is
    // ignored, and the duty always resets to the fixed RESET_DUTY value.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_duty_reg    <= bvsr_pkg::MAX_DUTY_RST;
            pwm_period_reg  <= bvsr_pkg::PWM_PERIOD_RST;
            drop_thresh_reg <= bvsr_pkg::DROP_THRESH_RST;
            down_step_reg   <= bvsr_pkg::DOWN_STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bvsr_pkg::CFG_MAX_DUTY:     max_duty_reg    <= cfg_wdata;
                bvsr_pkg::CFG_PWM_PERIOD:   pwm_period_reg  <= cfg_wdata;
                bvsr_pkg::CFG_DROP_THRESH:  drop_thresh_reg <= cfg_wdata[AW-1:0];
                bvsr_pkg::CFG_DOWN_STEP_MS: down_step_reg   <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // Duty step helpers.
    assign duty_inc    = duty_reg + 1'b1;
    assign duty_dec    = duty_reg - 1'b1;
    assign duty_at_max = (duty_reg > max_duty_reg) || (duty_reg == bvsr_pkg::DUTY_TOP);
    assign drop_seen   = (stable_reg >= drop_thresh_reg)
                         && (mean < (stable_reg - drop_thresh_reg));

    // Per-transaction state update.
    always_comb
    begin
        measured_next = measured_reg;
        target_next   = target_reg;
        stable_next   = stable_reg;
        phase_next    = phase_reg;
        enable_next   = enable_reg;
        duty_next     = duty_reg;
        compare_next  = compare_reg;
        wait_next     = wait_reg;
        if (accept)
        begin
            unique case (in_data.op)
                bvsr_pkg::OP_SAMPLE:
                begin
                end
                bvsr_pkg::OP_TICK:
                begin
                    if (wait_reg != '0)
                    begin
                        wait_next = wait_reg - 1'b1;
                    end
                end
                bvsr_pkg::OP_STEP:
                begin
                    measured_next = mean;
                    if (enable_reg)
                    begin
                        unique case (phase_reg)
                            bvsr_pkg::PH_RISE:
                            begin
                                if (mean < target_reg)
                                begin
                                    if (!duty_at_max)
                                    begin
                                        duty_next = duty_inc;
                                        if (duty_inc < pwm_period_reg)
                                        begin
                                            compare_next = duty_inc;
                                        end
                                    end
                                end
                                else
                                begin
                                    phase_next = bvsr_pkg::PH_FALL;
                                end
                            end
                            bvsr_pkg::PH_FALL:
                            begin
                                if (wait_reg == '0)
                                begin
                                    wait_next = down_step_reg;
                                    if (mean > target_reg)
                                    begin
                                        if (duty_reg >= bvsr_pkg::MIN_DUTY)
                                        begin
                                            duty_next = duty_dec;
                                            if (duty_dec < pwm_period_reg)
                                            begin
                                                compare_next = duty_dec;
                                            end
                                        end
                                    end
                                    else
                                    begin
                                        stable_next = mean;
                                        phase_next  = bvsr_pkg::PH_STABLE;
                                    end
                                end
                            end
                            bvsr_pkg::PH_STABLE:
                            begin
                                if (drop_seen)
                                begin
                                    phase_next = bvsr_pkg::PH_RISE;
                                end
                                else if (mean > target_reg)
                                begin
                                    phase_next = bvsr_pkg::PH_FALL;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                bvsr_pkg::OP_MODE:
                begin
                    if (in_data.cmd_manual)
                    begin
                        if (in_data.cmd_duty < pwm_period_reg)
                        begin
                            compare_next = in_data.cmd_duty;
                            duty_next    = in_data.cmd_duty;
                        end
                        enable_next = 1'b0;
                    end
                    else if (in_data.cmd_target_code != '0)
                    begin
                        target_next = in_data.cmd_target_code;
                        stable_next = in_data.cmd_target_code;
                        phase_next  = bvsr_pkg::PH_STABLE;
                        enable_next = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            measured_reg <= '0;
            target_reg   <= '0;
            stable_reg   <= '0;
            phase_reg    <= bvsr_pkg::PH_RISE;
            enable_reg   <= 1'b0;
            duty_reg     <= bvsr_pkg::RESET_DUTY;
            compare_reg  <= bvsr_pkg::RESET_DUTY;
            wait_reg     <= '0;
        end
        else
        begin
            measured_reg <= measured_next;
            target_reg   <= target_next;
            stable_reg   <= stable_next;
            phase_reg    <= phase_next;
            enable_reg   <= enable_next;
            duty_reg     <= duty_next;
            compare_reg  <= compare_next;
            wait_reg     <= wait_next;
        end
    end

    // The result reports the state left by the transaction.
    assign result.pwm_compare   = compare_next;
    assign result.measured_code = measured_next;
    assign result.loop_state    = phase_next;
    assign result.feedback_on   = enable_next;

    // Result buffer control: head slot drives the port, skid slot catches a
    // result while the head stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                head_valid_reg <= skid_valid_reg || accept;
                skid_valid_reg <= 1'b0;
            end
            else if (accept)
            begin
                if (head_valid_reg)
                begin
                    skid_valid_reg <= 1'b1;
                end
                else
                begin
                    head_valid_reg <= 1'b1;
                end
            end
        end
    end

    // Result buffer payload.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_reg <= skid_reg;
            end
            else if (accept)
            begin
                head_reg <= result;
            end
        end
        else if (accept)
        begin
            if (head_valid_reg)
            begin
                skid_reg <= result;
            end
            else
            begin
                head_reg <= result;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/bvsr_checker.sv]
// Port-level checks for the bias voltage step regulator, bound to the top level.
// Depends on bvsr_pkg and bias_voltage_step_regulator.
`timescale 1ns / 1ps
`default_nettype none

module bvsr_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire bvsr_pkg::out_item_t out_data
);

    // Every accepted transaction leaves a result visible in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> out_valid)
    else $error("no result after an accepted transaction");

    // The input side only stalls while a result is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

    // Input back-pressure needs a result stall in the cycle before.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> $past(out_valid && !out_ready))
    else $error("input stalled without an output stall");

    // A stalled result holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind bias_voltage_step_regulator bvsr_checker u_bvsr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for bias_voltage_step_regulator: it drives sample, tick, step and
// mode transactions with random idling on both channels and checks every result.
// Depends on bvsr_pkg and the regulator RTL.

module tb_top;

    localparam int AVG_SAMPLES = 32;
    localparam int CAPTURE_LEN = AVG_SAMPLES + 1;
    localparam int ADC_MAX     = (1 << bvsr_pkg::ADC_BITS) - 1;
    localparam int N_SETTINGS  = 8;
    localparam int TOP_SETTING = 5;
    localparam int PHASE_ITEMS = 212;
    localparam int IDLE_LIMIT  = 2000;
    localparam int MAX_REPORTS = 40;

    logic                             clk       = 1'b0;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    logic                             in_ready;
    bvsr_pkg::in_item_t               in_data   = '0;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    bvsr_pkg::out_item_t              out_data;
    logic                             cfg_we    = 1'b0;
    logic [bvsr_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [bvsr_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    bias_voltage_step_regulator #(
        .AVG_SAMPLES(AVG_SAMPLES)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Local copy of the configuration registers.
    logic [bvsr_pkg::DUTY_W-1:0]   max_duty_r, pwm_period_r, down_step_r, reset_duty_r;
    logic [bvsr_pkg::ADC_BITS-1:0] drop_r;

    // Local copy of the regulator state.
    logic [bvsr_pkg::ADC_BITS-1:0] cap_store [AVG_SAMPLES];
    logic [5:0]                    cap_index;
    logic [16:0]                   cap_sum;
    logic [bvsr_pkg::ADC_BITS-1:0] meas_code, target_code, stable_code;
    logic [bvsr_pkg::PHASE_W-1:0]  loop_phase;
    logic                          loop_on;
    logic [bvsr_pkg::DUTY_W-1:0]   duty_count, compare_value, fall_wait;

    bvsr_pkg::in_item_t  items_pending [$];
    bvsr_pkg::out_item_t results_due [$];

    bit in_fire     = 1'b0;
    int idle_cycles = 0;
    int burst_left  = 1;
    int gap_left    = 0;
    int ready_left  = 0;
    int n_errors    = 0;
    int n_checked   = 0;
    int n_steps     = 0;
    int n_captures  = 0;
    int n_queued    = 0;

    // Stimulus shaping hints that follow the programmed registers.
    int gen_target = 0;
    int gen_drop   = int'(bvsr_pkg::DROP_THRESH_RST);
    int gen_down   = int'(bvsr_pkg::DOWN_STEP_RST);
    int gen_period = int'(bvsr_pkg::PWM_PERIOD_RST);

    // Clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void clear_model();
        max_duty_r   = bvsr_pkg::MAX_DUTY_RST;
        pwm_period_r = bvsr_pkg::PWM_PERIOD_RST;
        drop_r       = bvsr_pkg::DROP_THRESH_RST;
        down_step_r  = bvsr_pkg::DOWN_STEP_RST;
        reset_duty_r = bvsr_pkg::RESET_DUTY;
        for (int i = 0; i < AVG_SAMPLES; i++)
            cap_store[i] = '0;
        cap_index     = '0;
        cap_sum       = '0;
        meas_code     = '0;
        target_code   = '0;
        stable_code   = '0;
        loop_phase    = bvsr_pkg::PH_RISE;
        loop_on       = 1'b0;
        duty_count    = bvsr_pkg::RESET_DUTY;
        compare_value = bvsr_pkg::RESET_DUTY;
        fall_wait     = '0;
    endfunction

    // A new duty reaches the PWM only when it is below the period.
    function automatic void set_duty(logic [bvsr_pkg::DUTY_W-1:0] d);
        if (d < pwm_period_r)
        begin
            compare_value = d;
            duty_count    = d;
        end
    endfunction

    function automatic void raise_duty();
        if (duty_count <= max_duty_r && duty_count != bvsr_pkg::DUTY_TOP)
        begin
            duty_count = duty_count + 1'b1;
            set_duty(duty_count);
        end
    endfunction

    function automatic void lower_duty();
        if (duty_count >= bvsr_pkg::MIN_DUTY)
        begin
            duty_count = duty_count - 1'b1;
            set_duty(duty_count);
        end
    endfunction

    // Three-phase feedback loop, run once per control step.
    function automatic void run_duty_loop();
        case (loop_phase)
            bvsr_pkg::PH_RISE:
                if (meas_code < target_code)
                    raise_duty();
                else
                    loop_phase = bvsr_pkg::PH_FALL;
            bvsr_pkg::PH_FALL:
                if (fall_wait == 0)
                begin
                    fall_wait = down_step_r;
                    if (meas_code > target_code)
                        lower_duty();
                    else
                    begin
                        stable_code = meas_code;
                        loop_phase  = bvsr_pkg::PH_STABLE;
                    end
                end
            bvsr_pkg::PH_STABLE:
                if (stable_code >= drop_r && meas_code < stable_code - drop_r)
                    loop_phase = bvsr_pkg::PH_RISE;
                else if (meas_code > target_code)
                    loop_phase = bvsr_pkg::PH_FALL;
            default: ;
        endcase
    endfunction

    // Applies one accepted transaction and returns the result it produces.
    function automatic bvsr_pkg::out_item_t regulate_step(bvsr_pkg::in_item_t it);
        bvsr_pkg::out_item_t res;
        logic [4:0]          slot;
        case (it.op)
            bvsr_pkg::OP_SAMPLE:
                if (cap_index < CAPTURE_LEN)
                begin
                    // The first sample of each capture is thrown away.
                    if (cap_index >= 1)
                    begin
                        slot            = 5'(cap_index - 1'b1);
                        cap_sum         = cap_sum - cap_store[slot] + it.sample;
                        cap_store[slot] = it.sample;
                    end
                    cap_index = cap_index + 1'b1;
                end
            bvsr_pkg::OP_TICK:
                if (fall_wait != 0)
                    fall_wait = fall_wait - 1'b1;
            bvsr_pkg::OP_STEP:
            begin
                meas_code = bvsr_pkg::ADC_BITS'(cap_sum / AVG_SAMPLES);
                n_steps++;
                if (cap_index >= CAPTURE_LEN)
                begin
                    cap_index = '0;
                    n_captures++;
                end
                if (loop_on)
                    run_duty_loop();
            end
            default:
                if (it.cmd_manual)
                begin
                    set_duty(it.cmd_duty);
                    loop_on = 1'b0;
                end
                else if (it.cmd_target_code != 0)
                begin
                    target_code = it.cmd_target_code;
                    stable_code = it.cmd_target_code;
                    loop_phase  = bvsr_pkg::PH_STABLE;
                    loop_on     = 1'b1;
                end
        endcase
        res.pwm_compare   = compare_value;
        res.measured_code = meas_code;
        res.loop_state    = loop_phase;
        res.feedback_on   = loop_on;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driver, receiver and monitor
    // ------------------------------------------------------------------

    // Input side: bursts of transactions separated by random gaps.
    always @(negedge clk)
    begin
        if (!in_valid || in_fire)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (items_pending.size() > 0)
            begin
                in_data  <= items_pending.pop_front();
                in_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result side: alternating ready runs and stalls of random length.
    always @(negedge clk)
    begin
        if (ready_left > 0)
            ready_left--;
        else
        begin
            out_ready <= !out_ready;
            if (out_ready)
                ready_left = $urandom_range(0, 11);
            else
                ready_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                          : $urandom_range(0, 20);
        end
    end

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("MISMATCH at result %0d, %s: got 0x%0h, expected 0x%0h",
                     n_checked, what, got, want);
    endtask

    // Checks results against the oldest expectation and predicts new ones.
    always @(posedge clk)
    begin : monitor
        bvsr_pkg::out_item_t want;
        logic                out_fire;
        if (rst_n)
        begin
            in_fire  = in_valid && in_ready;
            out_fire = out_valid && out_ready;
            if (out_fire)
            begin
                if (results_due.size() == 0)
                    report_mismatch("result with nothing expected", 32'(out_data), 0);
                else
                begin
                    want = results_due.pop_front();
                    if (out_data.pwm_compare !== want.pwm_compare)
                        report_mismatch("pwm_compare", 32'(out_data.pwm_compare),
                                        32'(want.pwm_compare));
                    if (out_data.measured_code !== want.measured_code)
                        report_mismatch("measured_code", 32'(out_data.measured_code),
                                        32'(want.measured_code));
                    if (out_data.loop_state !== want.loop_state)
                        report_mismatch("loop_state", 32'(out_data.loop_state),
                                        32'(want.loop_state));
                    if (out_data.feedback_on !== want.feedback_on)
                        report_mismatch("feedback_on", 32'(out_data.feedback_on),
                                        32'(want.feedback_on));
                end
                n_checked++;
            end
            if (in_fire)
                results_due.push_back(regulate_step(in_data));
            idle_cycles = (in_fire || out_fire) ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Watchdog: no transaction for %0d cycles.", IDLE_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic bvsr_pkg::in_item_t random_fields(logic [bvsr_pkg::OP_W-1:0] op);
        bvsr_pkg::in_item_t it;
        it.op              = op;
        it.sample          = bvsr_pkg::ADC_BITS'($urandom());
        it.cmd_manual      = 1'($urandom());
        it.cmd_duty        = bvsr_pkg::DUTY_W'($urandom());
        it.cmd_target_code = bvsr_pkg::ADC_BITS'($urandom());
        return it;
    endfunction

    task automatic queue_item(bvsr_pkg::in_item_t it);
        items_pending.push_back(it);
        n_queued++;
    endtask

    task automatic push_op(logic [bvsr_pkg::OP_W-1:0] op);
        queue_item(random_fields(op));
    endtask

    task automatic push_sample(int s);
        bvsr_pkg::in_item_t it;
        it        = random_fields(bvsr_pkg::OP_SAMPLE);
        it.sample = bvsr_pkg::ADC_BITS'(s);
        queue_item(it);
    endtask

    task automatic push_manual(int d);
        bvsr_pkg::in_item_t it;
        it            = random_fields(bvsr_pkg::OP_MODE);
        it.cmd_manual = 1'b1;
        it.cmd_duty   = bvsr_pkg::DUTY_W'(d);
        queue_item(it);
    endtask

    task automatic push_target(int t);
        bvsr_pkg::in_item_t it;
        it                 = random_fields(bvsr_pkg::OP_MODE);
        it.cmd_manual      = 1'b0;
        it.cmd_target_code = bvsr_pkg::ADC_BITS'(t);
        if (t != 0)
            gen_target = t;
        queue_item(it);
    endtask

    function automatic int clamp_code(int v);
        return (v < 0) ? 0 : ((v > ADC_MAX) ? ADC_MAX : v);
    endfunction

    // Picks a capture level below, near or above the current target.
    function automatic int pick_level();
        case ($urandom_range(0, 3))
            0:       return clamp_code(gen_target - gen_drop - int'($urandom_range(1, 300)));
            1:       return clamp_code(gen_target - int'($urandom_range(0, gen_drop)));
            2:       return gen_target;
            default: return clamp_code(gen_target + int'($urandom_range(1, 300)));
        endcase
    endfunction

    // A capture of noisy samples around one level, closed by a control step.
    // Some captures stop short; full ones may carry surplus samples.
    task automatic add_capture();
        int lvl;
        int n;
        int extra;
        lvl   = pick_level();
        n     = ($urandom_range(0, 5) == 0) ? int'($urandom_range(1, AVG_SAMPLES)) : CAPTURE_LEN;
        extra = (n == CAPTURE_LEN) ? int'($urandom_range(0, 3)) : 0;
        for (int i = 0; i < n + extra; i++)
        begin
            if ($urandom_range(0, 5) == 0)
                push_op(bvsr_pkg::OP_TICK);
            push_sample(clamp_code(lvl + int'($urandom_range(0, 16)) - 8));
        end
        push_op(bvsr_pkg::OP_STEP);
    endtask

    // Runs of control steps, with a few ticks after some of them.
    task automatic add_step_burst();
        int k;
        int tick_span;
        k         = $urandom_range(2, 16);
        tick_span = (gen_down > 6) ? 6 : gen_down;
        repeat (k)
        begin
            push_op(bvsr_pkg::OP_STEP);
            if ($urandom_range(0, 1) == 1)
                repeat ($urandom_range(1, tick_span)) push_op(bvsr_pkg::OP_TICK);
        end
    endtask

    task automatic add_mode();
        case ($urandom_range(0, 7))
            0:       push_target(0);
            1:       push_manual($urandom_range(0, gen_period));
            2:       push_manual($urandom_range(0, 65535));
            default: push_target($urandom_range(1, ADC_MAX));
        endcase
    endtask

    task automatic random_items(int budget);
        int stop_at;
        stop_at = n_queued + budget;
        while (n_queued < stop_at)
            case ($urandom_range(0, 9))
                0, 1, 2, 3: add_capture();
                4, 5:       add_step_burst();
                6:
                begin
                    repeat ($urandom_range(1, 8)) push_op(bvsr_pkg::OP_TICK);
                    push_op(bvsr_pkg::OP_STEP);
                end
                7, 8:       add_mode();
                default:    push_op(bvsr_pkg::OP_W'($urandom()));
            endcase
    endtask

    // ------------------------------------------------------------------
    // Configuration and phase control
    // ------------------------------------------------------------------

    task automatic write_reg(logic [bvsr_pkg::CFG_INDEX_W-1:0] idx,
                             logic [bvsr_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            bvsr_pkg::CFG_MAX_DUTY:     max_duty_r   = val;
            bvsr_pkg::CFG_PWM_PERIOD:   pwm_period_r = val;
            bvsr_pkg::CFG_DROP_THRESH:  drop_r       = val[bvsr_pkg::ADC_BITS-1:0];
            bvsr_pkg::CFG_DOWN_STEP_MS: down_step_r  = val;
            bvsr_pkg::CFG_RESET_DUTY:   reset_duty_r = val;
            default: ;
        endcase
    endtask

    // The unused upper bits of the threshold write are randomized.
    task automatic write_all(int max_d, int period, int drop, int down, int rst_d);
        write_reg(bvsr_pkg::CFG_MAX_DUTY, bvsr_pkg::CFG_DATA_W'(max_d));
        write_reg(bvsr_pkg::CFG_PWM_PERIOD, bvsr_pkg::CFG_DATA_W'(period));
        write_reg(bvsr_pkg::CFG_DROP_THRESH,
                  {4'($urandom()), bvsr_pkg::ADC_BITS'(drop)});
        write_reg(bvsr_pkg::CFG_DOWN_STEP_MS, bvsr_pkg::CFG_DATA_W'(down));
        write_reg(bvsr_pkg::CFG_RESET_DUTY, bvsr_pkg::CFG_DATA_W'(rst_d));
        gen_drop   = drop;
        gen_down   = down;
        gen_period = period;
    endtask

    // Waits until every queued transaction has produced its result.
    task automatic drain_block();
        while (items_pending.size() != 0 || in_valid || results_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        clear_model();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // Directed checks under the reset register values.
        push_op(bvsr_pkg::OP_STEP);         // measure an empty capture
        push_op(bvsr_pkg::OP_TICK);         // tick with the wait already at zero
        push_target(0);                     // zero target is ignored
        push_manual(int'(bvsr_pkg::DUTY_TOP)); // duty at or above the period is not applied
        push_sample(ADC_MAX);               // first sample is discarded
        push_sample(ADC_MAX);
        push_sample(0);
        push_op(bvsr_pkg::OP_STEP);         // partial capture measurement
        push_target(ADC_MAX);
        repeat (2) push_op(bvsr_pkg::OP_STEP); // stable drops to rising, then one increase
        push_manual(5);
        push_op(bvsr_pkg::OP_STEP);         // loop off: nothing moves
        push_target(1);                     // stable level below the drop threshold
        repeat (2) push_op(bvsr_pkg::OP_STEP); // to falling, then no decrease under the minimum
        push_op(bvsr_pkg::OP_TICK);
        push_op(bvsr_pkg::OP_STEP);         // falling while the step wait is running
        push_manual(int'(bvsr_pkg::PWM_PERIOD_RST) - 1);
        push_manual(int'(bvsr_pkg::PWM_PERIOD_RST));
        push_target(127);
        push_op(bvsr_pkg::OP_STEP);
        drain_block();

        for (int p = 0; p < N_SETTINGS; p++)
        begin
            case (p)
                0: write_all(1000, 2000, 100, 2, 100);
                1:
                begin
                    write_all(0, 1, 0, 1, 0);
                    // Indexes past the last register must be ignored.
                    for (int i = int'(bvsr_pkg::CFG_RESET_DUTY) + 1;
                         i < (1 << bvsr_pkg::CFG_INDEX_W); i++)
                        write_reg(bvsr_pkg::CFG_INDEX_W'(i),
                                  bvsr_pkg::CFG_DATA_W'($urandom()));
                end
                2: write_all(65535, 65535, ADC_MAX, 65535, 65535);
                3: write_all(120, 110, 30, 3, 7);
                TOP_SETTING: write_all(65535, 65535, 0, 1, 0);
                default: write_all($urandom_range(0, 3000), $urandom_range(50, 3000),
                                   $urandom_range(0, 400), $urandom_range(1, 6),
                                   $urandom_range(0, 65535));
            endcase
            @(negedge clk);
            cfg_we <= 1'b0;

            // Duty one below the top: one increase lands on the top and stops there.
            if (p == TOP_SETTING)
            begin
                push_manual(int'(bvsr_pkg::DUTY_TOP) - 1);
                push_target(ADC_MAX);
                repeat (3) push_op(bvsr_pkg::OP_STEP);
            end
            random_items(PHASE_ITEMS);
            drain_block();
        end

        if (results_due.size() != 0)
            report_mismatch("results never delivered", results_due.size(), 0);
        $display("Checked %0d results over %0d register settings:",
                 n_checked, N_SETTINGS + 1);
        $display("%0d control steps and %0d full captures.", n_steps, n_captures);
        $display("Mismatches: %0d", n_errors);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
